// ===== sv/sacu_pkg.sv =====
// Shared widths, payload types and helpers for the segment/box slab clip unit.
`default_nettype none
package sacu_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int NW    = CW + 1;
  localparam int RW    = NW + FB;
  localparam int TW    = FB + 2;
  localparam int NCELL = FB + 1;
  localparam int PW    = NW + FB + 2;
  localparam int NLANE = 6;

  localparam logic [FB:0]          Q_ONE  = {1'b1, {FB{1'b0}}};
  localparam logic signed [TW-1:0] T_ZERO = '0;
  localparam logic signed [TW-1:0] T_ONE  = {2'b01, {FB{1'b0}}};
  localparam logic signed [TW-1:0] T_OVER = {2'b01, {(FB-1){1'b0}}, 1'b1};
  localparam logic signed [TW-1:0] T_NEG  = '1;

  typedef struct packed {
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] finish_x;
    logic signed [CW-1:0] finish_y;
    logic signed [CW-1:0] finish_z;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [FB:0]          fraction;
    logic signed [CW-1:0] intersect_x;
    logic signed [CW-1:0] intersect_y;
    logic signed [CW-1:0] intersect_z;
  } res_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] den;
    logic [FB:0]   quot;
  } lane_t;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][NW-1:0] dir;
    logic [2:0]         dzero;
    logic [2:0]         inslab;
    logic [NLANE-1:0]   nzero;
    logic [NLANE-1:0]   negq;
    logic [NLANE-1:0]   ovf;
  } side_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lanes;
    side_t             side;
  } pipe_t;

  function automatic logic signed [TW-1:0] slab_value(
    input logic nzero, input logic negq, input logic ovf, input logic [FB:0] quot);
    logic signed [TW-1:0] t;
    if (nzero) t = T_ZERO;
    else if (negq) t = T_NEG;
    else if (ovf || quot > Q_ONE) t = T_OVER;
    else t = $signed({1'b0, quot});
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sacu_req_if.sv =====
// Request channel: box and segment with valid/ready.
`default_nettype none
interface sacu_req_if;
  logic             valid;
  logic             ready;
  sacu_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/sacu_res_if.sv =====
// Result channel: hit flag, entry fraction and entry point with valid/ready.
`default_nettype none
interface sacu_res_if;
  logic             valid;
  logic             ready;
  sacu_pkg::res_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/sacu_div_cell.sv =====
// One restoring division step for all six slab lanes, passing side data along.
`default_nettype none
module sacu_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire sacu_pkg::pipe_t pipe_in,
  output logic                 valid_out,
  output sacu_pkg::pipe_t      pipe_out
);
  import sacu_pkg::*;

  pipe_t pipe_next;

  always_comb begin
    pipe_next = pipe_in;
    for (int l = 0; l < NLANE; l++) begin
      if (pipe_in.lanes[l].rem >= pipe_in.lanes[l].den) begin
        pipe_next.lanes[l].rem = pipe_in.lanes[l].rem - pipe_in.lanes[l].den;
        pipe_next.lanes[l].quot = {pipe_in.lanes[l].quot[FB-1:0], 1'b1};
      end else begin
        pipe_next.lanes[l].quot = {pipe_in.lanes[l].quot[FB-1:0], 1'b0};
      end
      pipe_next.lanes[l].den = pipe_in.lanes[l].den >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_out <= pipe_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/segment_aabb_slab_clip_unit.sv =====
// Top level: segment versus axis-aligned box slab clip, fully pipelined.
// Stages from request to result: setup, 17 division cells, merge, multiply,
// output register; the division cells set the depth.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset: synchronous rst clears all stage valid flags; no request is in flight.
`default_nettype none
module segment_aabb_slab_clip_unit (
  input wire logic  clk,
  input wire logic  rst,
  sacu_req_if.sink   req,
  sacu_res_if.source res
);
  import sacu_pkg::*;

  logic adv;
  logic [2:0][CW-1:0] bmin, bmax, st, fn;
  pipe_t front;
  logic  chain_v [0:NCELL];
  pipe_t chain   [0:NCELL];

  logic                        m_valid, m_hit;
  logic [FB:0]                 m_lo;
  logic [2:0][CW-1:0]          m_s;
  logic [2:0][NW-1:0]          m_dir;
  logic                        m_hit_next;
  logic [FB:0]                 m_lo_next;

  logic                        p_valid, p_hit;
  logic [FB:0]                 p_lo;
  logic [2:0][CW-1:0]          p_s;
  logic [2:0][PW-1:0]          p_prod;

  res_t res_next;

  assign adv = !res.valid || res.ready;
  assign req.ready = adv;

  assign bmin = {req.payload.box_min_z, req.payload.box_min_y, req.payload.box_min_x};
  assign bmax = {req.payload.box_max_z, req.payload.box_max_y, req.payload.box_max_x};
  assign st   = {req.payload.start_z, req.payload.start_y, req.payload.start_x};
  assign fn   = {req.payload.finish_z, req.payload.finish_y, req.payload.finish_x};

  always_comb begin
    logic signed [NW-1:0] sx, d, n;
    logic [NW-1:0] un, ud;
    front = '0;
    for (int a = 0; a < 3; a++) begin
      sx = $signed({st[a][CW-1], st[a]});
      d  = $signed({fn[a][CW-1], fn[a]}) - sx;
      front.side.s[a] = st[a];
      front.side.dir[a] = d;
      front.side.dzero[a] = (d == '0);
      front.side.inslab[a] = ($signed(st[a]) >= $signed(bmin[a])) &&
                             ($signed(st[a]) <= $signed(bmax[a]));
      ud = d[NW-1] ? NW'(-d) : d;
      for (int b = 0; b < 2; b++) begin
        n = (b == 0) ? $signed({bmin[a][CW-1], bmin[a]}) - sx
                     : $signed({bmax[a][CW-1], bmax[a]}) - sx;
        un = n[NW-1] ? NW'(-n) : n;
        front.side.nzero[2*a+b] = (n == '0);
        front.side.negq[2*a+b] = n[NW-1] ^ d[NW-1];
        front.side.ovf[2*a+b] = {1'b0, un} >= {ud, 1'b0};
        front.lanes[2*a+b].rem = {un, {FB{1'b0}}};
        front.lanes[2*a+b].den = {ud, {FB{1'b0}}};
        front.lanes[2*a+b].quot = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else if (adv) begin
      chain_v[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0] <= front;
    end
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    sacu_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (chain_v[c]),
      .pipe_in   (chain[c]),
      .valid_out (chain_v[c+1]),
      .pipe_out  (chain[c+1])
    );
  end

  always_comb begin
    logic signed [TW-1:0] lo, hi, t0, t1, tn, tf;
    logic ok;
    lo = T_ZERO;
    hi = T_ONE;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      t0 = slab_value(chain[NCELL].side.nzero[2*a], chain[NCELL].side.negq[2*a],
                      chain[NCELL].side.ovf[2*a], chain[NCELL].lanes[2*a].quot);
      t1 = slab_value(chain[NCELL].side.nzero[2*a+1], chain[NCELL].side.negq[2*a+1],
                      chain[NCELL].side.ovf[2*a+1], chain[NCELL].lanes[2*a+1].quot);
      tn = (t0 < t1) ? t0 : t1;
      tf = (t0 < t1) ? t1 : t0;
      if (chain[NCELL].side.dzero[a]) begin
        ok = ok && chain[NCELL].side.inslab[a];
      end else begin
        if (tn > lo) lo = tn;
        if (tf < hi) hi = tf;
      end
    end
    m_hit_next = ok && (lo <= hi);
    m_lo_next = lo[FB:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      m_valid <= chain_v[NCELL];
      p_valid <= m_valid;
      res.valid <= p_valid;
    end
  end

  always_comb begin
    logic signed [PW-1:0] sh;
    sh = '0;
    res_next = '0;
    if (p_hit) begin
      res_next.hit = 1'b1;
      res_next.fraction = p_lo;
      sh = $signed(p_prod[0]) >>> FB;
      res_next.intersect_x = $signed(p_s[0]) + $signed(sh[CW-1:0]);
      sh = $signed(p_prod[1]) >>> FB;
      res_next.intersect_y = $signed(p_s[1]) + $signed(sh[CW-1:0]);
      sh = $signed(p_prod[2]) >>> FB;
      res_next.intersect_z = $signed(p_s[2]) + $signed(sh[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_hit <= m_hit_next;
      m_lo  <= m_lo_next;
      m_s   <= chain[NCELL].side.s;
      m_dir <= chain[NCELL].side.dir;
      p_hit <= m_hit;
      p_lo  <= m_lo;
      p_s   <= m_s;
      for (int a = 0; a < 3; a++) begin
        p_prod[a] <= PW'($signed(m_dir[a]) * $signed({1'b0, m_lo}));
      end
      res.payload <= res_next;
    end
  end

endmodule
`default_nettype wire
